@@ hdl/jmsw_pkg.sv @@
package jmsw_pkg;

	typedef enum logic [3:0] {
		PH_START0 = 4'd0,
		PH_START1 = 4'd1,
		PH_PREFIX = 4'd2,
		PH_CODE   = 4'd3,
		PH_LENHI  = 4'd4,
		PH_LENLO  = 4'd5,
		PH_SKIP   = 4'd6,
		PH_SCAN   = 4'd7,
		PH_DONE   = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		EV_SEGMENT    = 3'd0,
		EV_SCAN       = 3'd1,
		EV_APP1       = 3'd2,
		EV_EOI        = 3'd3,
		EV_BAD_START  = 3'd4,
		EV_BAD_PREFIX = 3'd5,
		EV_BAD_LENGTH = 3'd6,
		EV_STREAM_END = 3'd7
	} ev_kind_t;

	localparam logic [7:0] MK_PREFIX = 8'hFF;
	localparam logic [7:0] MK_SOI    = 8'hD8;
	localparam logic [7:0] MK_EOI    = 8'hD9;
	localparam logic [7:0] MK_APP1   = 8'hE1;
	localparam logic [7:0] MK_RST0   = 8'hD0;
	localparam logic [7:0] MK_SOS    = 8'hDA;
	localparam logic [7:0] MK_STUFF  = 8'h00;

	localparam logic [15:0] MIN_SEG_LEN = 16'd2;

	function automatic logic is_scan_code(input logic [7:0] code);
		return ((code >= MK_RST0) && (code <= MK_SOI)) || (code == MK_SOS);
	endfunction

endpackage

@@ hdl/jmsw_byte_if.sv @@
interface jmsw_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ hdl/jmsw_event_if.sv @@
interface jmsw_event_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_kind;
	logic [7:0]  marker_code;
	logic [15:0] segment_length;
	logic [31:0] marker_offset;

	modport source (output valid, output event_kind, output marker_code,
		output segment_length, output marker_offset, input ready);
	modport sink (input valid, input event_kind, input marker_code,
		input segment_length, input marker_offset, output ready);
endinterface

@@ hdl/jpeg_marker_segment_walker_core.sv @@
// An event is registered and appears on event_ch in the cycle after the byte that causes it.
// Throughput: one byte per cycle while data_ch is ready; a single state update per byte sets the rate.
// data_ch stays ready while the event register is empty or being drained.
// Reset (arst_n low) returns to the start-of-image check and clears position counters.
// After an end, APP1, error or final byte, bytes are taken and dropped until reset.
module jpeg_marker_segment_walker_core #(
	parameter int POSITION_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	jmsw_byte_if.sink           data_ch,
	jmsw_event_if.source        event_ch
);

	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	jmsw_pkg::phase_t phase_q, phase_d;
	logic [15:0] skip_q, skip_d;
	logic        ff_q, ff_d;
	logic [7:0]  code_q, code_d;
	logic [7:0]  lenhi_q, lenhi_d;
	logic [POSITION_BITS-1:0] bpos_q;
	logic [POSITION_BITS-1:0] mpos_q, mpos_d;

	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [7:0]  mcode_q;
	logic [15:0] slen_q;
	logic [31:0] moff_q;

	logic        in_ready;
	logic        acc;
	logic [7:0]  b;
	logic [15:0] len;

	logic             tk_hit;
	jmsw_pkg::ev_kind_t tk_kind;
	jmsw_pkg::phase_t tk_phase;

	logic             hit;
	jmsw_pkg::ev_kind_t kind;

	logic [7:0]  res_code;
	logic [15:0] res_len;
	logic [POSITION_BITS-1:0] res_pos;
	logic [63:0] res_pos_ext;
	logic [31:0] res_off;

	assign in_ready      = !out_valid_q || event_ch.ready;
	assign data_ch.ready = in_ready;
	assign acc           = data_ch.valid && in_ready;
	assign b             = data_ch.data_byte;
	assign len           = {lenhi_q, b};

	always_comb begin
		tk_hit   = 1'b1;
		tk_kind  = jmsw_pkg::EV_SCAN;
		tk_phase = jmsw_pkg::PH_SCAN;
		priority if (jmsw_pkg::is_scan_code(b)) begin
			tk_kind  = jmsw_pkg::EV_SCAN;
			tk_phase = jmsw_pkg::PH_SCAN;
		end else if (b == jmsw_pkg::MK_EOI) begin
			tk_kind  = jmsw_pkg::EV_EOI;
			tk_phase = jmsw_pkg::PH_DONE;
		end else if (b == jmsw_pkg::MK_APP1) begin
			tk_kind  = jmsw_pkg::EV_APP1;
			tk_phase = jmsw_pkg::PH_DONE;
		end else begin
			tk_hit   = 1'b0;
			tk_phase = jmsw_pkg::PH_LENHI;
		end
	end

	always_comb begin
		phase_d = phase_q;
		skip_d  = skip_q;
		ff_d    = ff_q;
		code_d  = code_q;
		lenhi_d = lenhi_q;
		mpos_d  = mpos_q;
		hit     = 1'b0;
		kind    = jmsw_pkg::EV_SEGMENT;
		unique case (phase_q)
			jmsw_pkg::PH_START0: begin
				if (b != jmsw_pkg::MK_PREFIX) begin
					hit     = 1'b1;
					kind    = jmsw_pkg::EV_BAD_START;
					phase_d = jmsw_pkg::PH_DONE;
				end else begin
					phase_d = jmsw_pkg::PH_START1;
				end
			end
			jmsw_pkg::PH_START1: begin
				if (b != jmsw_pkg::MK_SOI) begin
					hit     = 1'b1;
					kind    = jmsw_pkg::EV_BAD_START;
					phase_d = jmsw_pkg::PH_DONE;
				end else begin
					phase_d = jmsw_pkg::PH_PREFIX;
				end
			end
			jmsw_pkg::PH_PREFIX: begin
				if (b != jmsw_pkg::MK_PREFIX) begin
					hit     = 1'b1;
					kind    = jmsw_pkg::EV_BAD_PREFIX;
					phase_d = jmsw_pkg::PH_DONE;
				end else begin
					mpos_d  = bpos_q;
					phase_d = jmsw_pkg::PH_CODE;
				end
			end
			jmsw_pkg::PH_CODE: begin
				code_d  = b;
				hit     = tk_hit;
				kind    = tk_kind;
				phase_d = tk_phase;
				ff_d    = 1'b0;
			end
			jmsw_pkg::PH_LENHI: begin
				lenhi_d = b;
				phase_d = jmsw_pkg::PH_LENLO;
			end
			jmsw_pkg::PH_LENLO: begin
				hit = 1'b1;
				if (len < jmsw_pkg::MIN_SEG_LEN) begin
					kind    = jmsw_pkg::EV_BAD_LENGTH;
					phase_d = jmsw_pkg::PH_DONE;
				end else begin
					kind    = jmsw_pkg::EV_SEGMENT;
					skip_d  = len - jmsw_pkg::MIN_SEG_LEN;
					phase_d = (len == jmsw_pkg::MIN_SEG_LEN) ? jmsw_pkg::PH_PREFIX
						: jmsw_pkg::PH_SKIP;
				end
			end
			jmsw_pkg::PH_SKIP: begin
				if (skip_q != 16'd0) begin
					skip_d = skip_q - 16'd1;
				end
				if (skip_q <= 16'd1) begin
					phase_d = jmsw_pkg::PH_PREFIX;
				end
			end
			jmsw_pkg::PH_SCAN: begin
				if (ff_q) begin
					ff_d = 1'b0;
					if (b != jmsw_pkg::MK_STUFF) begin
						code_d  = b;
						hit     = tk_hit;
						kind    = tk_kind;
						phase_d = tk_phase;
					end
				end else if (b == jmsw_pkg::MK_PREFIX) begin
					ff_d   = 1'b1;
					mpos_d = bpos_q;
				end
			end
			jmsw_pkg::PH_DONE: begin
				phase_d = jmsw_pkg::PH_DONE;
			end
			default: begin
				phase_d = jmsw_pkg::PH_DONE;
			end
		endcase
		if (data_ch.last_byte && phase_d != jmsw_pkg::PH_DONE) begin
			if (!hit) begin
				hit  = 1'b1;
				kind = jmsw_pkg::EV_STREAM_END;
			end
			phase_d = jmsw_pkg::PH_DONE;
			ff_d    = 1'b0;
		end
	end

	always_comb begin
		res_code = 8'd0;
		res_len  = 16'd0;
		res_pos  = mpos_q;
		unique case (kind)
			jmsw_pkg::EV_SEGMENT, jmsw_pkg::EV_BAD_LENGTH: begin
				res_code = code_q;
				res_len  = len;
			end
			jmsw_pkg::EV_SCAN, jmsw_pkg::EV_APP1, jmsw_pkg::EV_EOI: begin
				res_code = b;
			end
			jmsw_pkg::EV_BAD_START, jmsw_pkg::EV_BAD_PREFIX,
			jmsw_pkg::EV_STREAM_END: begin
				res_pos = bpos_q;
			end
			default: begin
				res_pos = bpos_q;
			end
		endcase
		res_pos_ext = 64'(res_pos);
		res_off     = (|res_pos_ext[63:32]) ? 32'hFFFF_FFFF : res_pos_ext[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jmsw_pkg::PH_START0;
			skip_q  <= '0;
			ff_q    <= 1'b0;
			code_q  <= '0;
			lenhi_q <= '0;
			bpos_q  <= '0;
			mpos_q  <= '0;
		end else if (acc && phase_q != jmsw_pkg::PH_DONE) begin
			phase_q <= phase_d;
			skip_q  <= skip_d;
			ff_q    <= ff_d;
			code_q  <= code_d;
			lenhi_q <= lenhi_d;
			mpos_q  <= mpos_d;
			if (bpos_q != POS_MAX) begin
				bpos_q <= bpos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && hit && phase_q != jmsw_pkg::PH_DONE) begin
			out_valid_q <= 1'b1;
		end else if (event_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && hit && phase_q != jmsw_pkg::PH_DONE) begin
			kind_q  <= kind;
			mcode_q <= res_code;
			slen_q  <= res_len;
			moff_q  <= res_off;
		end
	end

	assign event_ch.valid          = out_valid_q;
	assign event_ch.event_kind     = kind_q;
	assign event_ch.marker_code    = mcode_q;
	assign event_ch.segment_length = slen_q;
	assign event_ch.marker_offset  = moff_q;

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == jmsw_pkg::PH_DONE && !out_valid_q) |=> !out_valid_q)
		else $error("event raised after parsing stopped");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == jmsw_pkg::PH_SKIP) |-> (skip_q != 16'd0))
		else $error("skip phase with nothing left to skip");

	a_ff_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ff_q |-> (phase_q == jmsw_pkg::PH_SCAN))
		else $error("pending prefix outside entropy data");

	a_stream_evt_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (kind_q == jmsw_pkg::EV_BAD_START
			|| kind_q == jmsw_pkg::EV_BAD_PREFIX
			|| kind_q == jmsw_pkg::EV_STREAM_END)) |-> (mcode_q == 8'd0 && slen_q == 16'd0))
		else $error("stream event carries a marker code or length");

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		!data_ch.ready |-> (out_valid_q && !event_ch.ready))
		else $error("input stalled while the event register can move");

endmodule
